@@ design/chm_pkg.sv @@
// ----------------------------------------------------------------------------
// chm_pkg
// Shared constants and types for the chained hash attribute map.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int BUCKETS    = 1024;
    localparam int POOL_NODES = 2048;
    localparam int HASH_SHIFT = 12;

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int IDX_W  = $clog2(POOL_NODES);
    localparam int LINK_W = $clog2(POOL_NODES + 1);
    localparam int KEY_W  = 64;
    localparam int VAL_W  = 32;
    // only the low bits of the key reach the bucket bits of key*key
    localparam int SQ_W   = HASH_SHIFT + BKT_W;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SLOT_SET = 2'd1,
        ST_POOL_FULL = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  use_val;
        logic [VAL_W-1:0]  def_val;
        logic [LINK_W-1:0] next;
    } node_t;

endpackage

@@ design/chained_hash_attribute_map_top.sv @@
// ----------------------------------------------------------------------------
// chained_hash_attribute_map_top
// Hash map of 64-bit keys to use/def handle pairs, chained through a node pool.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (cmd, key, side, value_in) is taken at a clock edge where
//   start is high and busy is low. Each command yields exactly one result
//   word on value_out/found/status, shown for one cycle with done high. The
//   receiver cannot stall; the result must be taken in that cycle.
// Sequence:
//   Insert/lookup: bucket index registered, head read (S_BKT, S_HEAD), then
//   per chain node a check and a node read (S_CHK, S_NODE), then the result.
//   Clear: one bucket head per cycle through all 1024 buckets, then the result.
//   The chain walk is paced by the registered node memory read.
// Reset:
//   rst_n clears control state; afterwards a sweep of all 1024 bucket heads
//   zeroes them with busy high and no result word. Node memory is not
//   cleared: only allocated nodes are ever reachable.
// ----------------------------------------------------------------------------
module chained_hash_attribute_map_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 cmd,
    input  logic [chm_pkg::KEY_W-1:0]  key,
    input  logic                       side,
    input  logic [chm_pkg::VAL_W-1:0]  value_in,
    output logic                       done,
    output logic [chm_pkg::VAL_W-1:0]  value_out,
    output logic                       found,
    output logic [1:0]                 status
);
    import chm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR,
        S_BKT,
        S_HEAD,
        S_CHK,
        S_NODE
    } state_t;

    state_t              state_reg;
    logic [1:0]          cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    logic                side_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [BKT_W-1:0]    bkt_reg;
    logic [LINK_W-1:0]   head_reg;
    logic [LINK_W-1:0]   link_reg;
    logic [LINK_W-1:0]   count_reg;
    logic [BKT_W-1:0]    clr_idx_reg;
    logic                clr_report_reg;
    logic                done_reg;
    logic [VAL_W-1:0]    vout_reg;
    logic                found_reg;
    logic [1:0]          status_reg;

    // bucket head memory
    logic [LINK_W-1:0]   bh_mem [BUCKETS];
    logic [LINK_W-1:0]   bh_rdata_reg;
    logic                bh_we;
    logic [BKT_W-1:0]    bh_waddr;
    logic [LINK_W-1:0]   bh_wdata;

    // node memory
    node_t               nd_mem [POOL_NODES];
    node_t               nd_rdata_reg;
    logic                nd_we;
    logic [IDX_W-1:0]    nd_waddr;
    node_t               nd_wdata;
    logic [IDX_W-1:0]    nd_raddr;

    logic [2*SQ_W-1:0]   sq_full;
    logic [LINK_W-1:0]   link_m1;
    logic                link_ok;
    logic                pool_full;
    logic [VAL_W-1:0]    slot_val;

    assign sq_full   = (2*SQ_W)'(key[SQ_W-1:0]) * (2*SQ_W)'(key[SQ_W-1:0]);
    assign link_m1   = link_reg - LINK_W'(1);
    assign link_ok   = (link_reg != '0) && (link_reg <= LINK_W'(POOL_NODES));
    assign pool_full = (count_reg >= LINK_W'(POOL_NODES));
    assign nd_raddr  = link_m1[IDX_W-1:0];
    assign slot_val  = side_reg ? nd_rdata_reg.def_val : nd_rdata_reg.use_val;

    always_ff @(posedge clk) begin
        if (bh_we) begin
            bh_mem[bh_waddr] <= bh_wdata;
        end
        bh_rdata_reg <= bh_mem[bkt_reg];
    end

    always_ff @(posedge clk) begin
        if (nd_we) begin
            nd_mem[nd_waddr] <= nd_wdata;
        end
        nd_rdata_reg <= nd_mem[nd_raddr];
    end

    // memory write ports
    always_comb begin
        bh_we    = 1'b0;
        bh_waddr = bkt_reg;
        bh_wdata = '0;
        nd_we    = 1'b0;
        nd_waddr = count_reg[IDX_W-1:0];
        nd_wdata = nd_rdata_reg;
        unique case (state_reg)
            S_IDLE: ;
            S_CLR: begin
                bh_we    = 1'b1;
                bh_waddr = clr_idx_reg;
            end
            S_BKT: ;
            S_HEAD: ;
            S_CHK: begin
                if (!link_ok && cmd_reg == CMD_INSERT && !pool_full) begin
                    // new node at chain head, selected slot filled directly
                    bh_we            = 1'b1;
                    bh_wdata         = count_reg + LINK_W'(1);
                    nd_we            = 1'b1;
                    nd_wdata.key     = key_reg;
                    nd_wdata.use_val = side_reg ? '0 : val_reg;
                    nd_wdata.def_val = side_reg ? val_reg : '0;
                    nd_wdata.next    = head_reg;
                end
            end
            S_NODE: begin
                if (nd_rdata_reg.key == key_reg && cmd_reg == CMD_INSERT
                    && slot_val == '0) begin
                    nd_we    = 1'b1;
                    nd_waddr = link_m1[IDX_W-1:0];
                    if (side_reg) begin
                        nd_wdata.def_val = val_reg;
                    end else begin
                        nd_wdata.use_val = val_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= S_CLR;
            clr_idx_reg    <= '0;
            clr_report_reg <= 1'b0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            vout_reg       <= '0;
            found_reg      <= 1'b0;
            status_reg     <= ST_OK;
            cmd_reg        <= CMD_NOP;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        cmd_reg  <= cmd;
                        key_reg  <= key;
                        side_reg <= side;
                        val_reg  <= value_in;
                        bkt_reg  <= sq_full[HASH_SHIFT +: BKT_W];
                        unique case (cmd)
                            CMD_INSERT, CMD_LOOKUP: state_reg <= S_BKT;
                            CMD_CLEAR: begin
                                clr_idx_reg    <= '0;
                                clr_report_reg <= 1'b1;
                                count_reg      <= '0;
                                state_reg      <= S_CLR;
                            end
                            default: begin
                                done_reg   <= 1'b1;
                                vout_reg   <= '0;
                                found_reg  <= 1'b0;
                                status_reg <= ST_OK;
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    clr_idx_reg <= clr_idx_reg + BKT_W'(1);
                    if (clr_idx_reg == BKT_W'(BUCKETS - 1)) begin
                        state_reg  <= S_IDLE;
                        done_reg   <= clr_report_reg;
                        vout_reg   <= '0;
                        found_reg  <= 1'b0;
                        status_reg <= ST_OK;
                    end
                end
                S_BKT: begin
                    state_reg <= S_HEAD;   // head read in flight
                end
                S_HEAD: begin
                    head_reg  <= bh_rdata_reg;
                    link_reg  <= bh_rdata_reg;
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    if (link_ok) begin
                        state_reg <= S_NODE;   // node read in flight
                    end else begin
                        state_reg  <= S_IDLE;
                        done_reg   <= 1'b1;
                        vout_reg   <= '0;
                        found_reg  <= 1'b0;
                        status_reg <= ST_OK;
                        if (cmd_reg == CMD_INSERT) begin
                            if (pool_full) begin
                                status_reg <= ST_POOL_FULL;
                            end else begin
                                count_reg <= count_reg + LINK_W'(1);
                            end
                        end
                    end
                end
                S_NODE: begin
                    if (nd_rdata_reg.key == key_reg) begin
                        state_reg  <= S_IDLE;
                        done_reg   <= 1'b1;
                        vout_reg   <= '0;
                        found_reg  <= 1'b0;
                        status_reg <= ST_OK;
                        if (cmd_reg == CMD_LOOKUP) begin
                            vout_reg  <= slot_val;
                            found_reg <= 1'b1;
                        end else if (slot_val != '0) begin
                            status_reg <= ST_SLOT_SET;
                        end
                    end else begin
                        link_reg  <= nd_rdata_reg.next;
                        state_reg <= S_CHK;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign value_out = vout_reg;
    assign found     = found_reg;
    assign status    = status_reg;

endmodule

@@ test/chm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_checker
// Watches the command and result words of the attribute map, keeps its own
// copy of the table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module chm_checker
    import chm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [1:0]        cmd,
    input  logic [KEY_W-1:0]  key,
    input  logic              side,
    input  logic [VAL_W-1:0]  value_in,
    input  logic              done,
    input  logic [VAL_W-1:0]  value_out,
    input  logic              found,
    input  logic [1:0]        status,
    output int                pending,
    output int                fail_count
);

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             hit;
        status_t          stat;
    } answer_t;

    // shadow table
    int unsigned       heads [BUCKETS];
    logic [KEY_W-1:0]  keys  [POOL_NODES];
    logic [VAL_W-1:0]  uses  [POOL_NODES];
    logic [VAL_W-1:0]  defs  [POOL_NODES];
    int unsigned       links [POOL_NODES];
    int unsigned       used;

    answer_t expected_answers [$];

    function automatic int unsigned bucket_of(logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] sq;
        sq = k * k;
        return 32'((sq >> HASH_SHIFT) % BUCKETS);
    endfunction

    // node index plus one, 0 when absent
    function automatic int unsigned find_node(logic [KEY_W-1:0] k);
        int unsigned lnk;
        int unsigned steps;
        lnk = heads[bucket_of(k)];
        steps = 0;
        while (lnk != 0 && lnk <= POOL_NODES && steps < POOL_NODES)
        begin
            if (keys[lnk-1] == k)
                return lnk;
            lnk = links[lnk-1];
            steps++;
        end
        return 0;
    endfunction

    function automatic answer_t apply_command(cmd_t c, logic [KEY_W-1:0] k, logic s,
                                              logic [VAL_W-1:0] v);
        answer_t a;
        int unsigned lnk;
        int unsigned b;
        a = '{value: '0, hit: 1'b0, stat: ST_OK};
        case (c)
            CMD_INSERT:
            begin
                lnk = find_node(k);
                if (lnk == 0)
                begin
                    if (used >= POOL_NODES)
                        a.stat = ST_POOL_FULL;
                    else
                    begin
                        b = bucket_of(k);
                        keys[used]  = k;
                        uses[used]  = '0;
                        defs[used]  = '0;
                        links[used] = heads[b];
                        heads[b]    = used + 1;
                        used++;
                        lnk = used;
                    end
                end
                if (lnk != 0)
                begin
                    if ((s ? defs[lnk-1] : uses[lnk-1]) != 0)
                        a.stat = ST_SLOT_SET;
                    else if (s)
                        defs[lnk-1] = v;
                    else
                        uses[lnk-1] = v;
                end
            end
            CMD_LOOKUP:
            begin
                lnk = find_node(k);
                if (lnk != 0)
                begin
                    a.hit   = 1'b1;
                    a.value = s ? defs[lnk-1] : uses[lnk-1];
                end
            end
            CMD_CLEAR:
            begin
                foreach (heads[i])
                    heads[i] = 0;
                used = 0;
            end
            default: ;
        endcase
        return a;
    endfunction

    initial
    begin
        foreach (heads[i])
            heads[i] = 0;
        used = 0;
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: result word with nothing expected: value %h found %b status %0d",
                             $time, value_out, found, status);
                    fail_count++;
                end
                else
                begin
                    e = expected_answers.pop_front();
                    if (value_out !== e.value)
                    begin
                        $display("%0t: value_out expected %h actual %h", $time, e.value, value_out);
                        fail_count++;
                    end
                    if (found !== e.hit)
                    begin
                        $display("%0t: found expected %b actual %b", $time, e.hit, found);
                        fail_count++;
                    end
                    if (status !== e.stat)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time, e.stat, status);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_answers.push_back(apply_command(cmd_t'(cmd), key, side, value_in));
            pending = expected_answers.size();
        end
    end

endmodule

@@ test/tb_chained_hash_attribute_map_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_hash_attribute_map_top
// Drives command words into the attribute map: a directed opening, a burst
// of fresh keys with no gaps, then random traffic, mostly over a small key
// set, idle gaps but for one stretch. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_chained_hash_attribute_map_top;
    import chm_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int FILL_WORDS = 64;
    localparam int RANDOM_WORDS = 460;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        cmd;
    logic [KEY_W-1:0]  key;
    logic              side;
    logic [VAL_W-1:0]  value_in;
    logic              done;
    logic [VAL_W-1:0]  value_out;
    logic              found;
    logic [1:0]        status;
    int                pending;
    int                fail_count;
    int                cycles;
    logic              allow_gaps;

    // keys reused by the random part so inserts and lookups hit each other
    logic [KEY_W-1:0]  hot_keys [24];

    chained_hash_attribute_map_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .key       (key),
        .side      (side),
        .value_in  (value_in),
        .done      (done),
        .value_out (value_out),
        .found     (found),
        .status    (status)
    );

    chm_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .key        (key),
        .side       (side),
        .value_in   (value_in),
        .done       (done),
        .value_out  (value_out),
        .found      (found),
        .status     (status),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // present one word from a falling edge and hold it until it is taken
    task automatic send_word(cmd_t c, logic [KEY_W-1:0] k, logic s, logic [VAL_W-1:0] v);
        if (allow_gaps && $urandom_range(99) < 38)
        begin
            start = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        start    = 1'b1;
        cmd      = c;
        key      = k;
        side     = s;
        value_in = v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        start = 1'b0;
    endtask

    // random value: zero now and then so empty-slot inserts show up
    function automatic logic [VAL_W-1:0] rand_value();
        if ($urandom_range(9) == 0)
            return '0;
        return $urandom;
    endfunction

    initial
    begin
        logic [KEY_W-1:0] k;
        int unsigned r;
        cmd_t c;
        start      = 1'b0;
        cmd        = CMD_NOP;
        key        = '0;
        side       = 1'b0;
        value_in   = '0;
        allow_gaps = 1'b1;
        rst_n      = 1'b0;
        foreach (hot_keys[i])
            hot_keys[i] = (i < 8) ? KEY_W'(i) : rand_key();
        hot_keys[8] = '1;
        hot_keys[9] = 64'h8000_0000_0000_0000;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed opening: extremes, slot-set, zero value, miss, nop, clear
        send_word(CMD_LOOKUP, '0, 1'b0, '0);
        send_word(CMD_INSERT, '0, 1'b0, '1);
        send_word(CMD_INSERT, '0, 1'b0, 32'h1234_5678);
        send_word(CMD_INSERT, '0, 1'b1, '0);
        send_word(CMD_LOOKUP, '0, 1'b1, '0);
        send_word(CMD_INSERT, '0, 1'b1, 32'h0000_0001);
        send_word(CMD_LOOKUP, '0, 1'b0, '0);
        send_word(CMD_LOOKUP, '0, 1'b1, '0);
        send_word(CMD_INSERT, '1, 1'b1, 32'h8000_0000);
        send_word(CMD_LOOKUP, '1, 1'b1, '0);
        send_word(CMD_LOOKUP, '1, 1'b0, '0);
        send_word(CMD_LOOKUP, 64'h0000_0000_0000_1000, 1'b0, '0);
        // low bits zero, so same bucket as keys 0 and all ones: chain of three
        send_word(CMD_INSERT, 64'h0001_0000_0000_0000, 1'b0, 32'hA5A5_A5A5);
        send_word(CMD_LOOKUP, 64'h0001_0000_0000_0000, 1'b0, '0);
        send_word(CMD_LOOKUP, '0, 1'b0, '0);
        send_word(CMD_NOP, '1, 1'b1, '1);
        send_word(CMD_CLEAR, '0, 1'b0, '0);
        send_word(CMD_LOOKUP, '0, 1'b0, '0);
        send_word(CMD_LOOKUP, '1, 1'b1, '0);

        // burst of fresh keys without gaps, then revisit one of them
        allow_gaps = 1'b0;
        for (int i = 0; i < FILL_WORDS; i++)
            send_word(CMD_INSERT, KEY_W'(i) * 64'h9E37_79B9_7F4A_7C15, i[0], rand_value());
        send_word(CMD_INSERT, 64'h9E37_79B9_7F4A_7C15, 1'b1, 32'h7);
        send_word(CMD_LOOKUP, 64'h9E37_79B9_7F4A_7C15, 1'b0, '0);

        // hold off until the table has answered everything
        wait (pending == 0);
        @(negedge clk);
        send_word(CMD_CLEAR, '0, 1'b0, '0);
        allow_gaps = 1'b1;

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            allow_gaps = !(i >= 200 && i < 280);
            r = $urandom_range(99);
            if (r < 46)
                c = CMD_INSERT;
            else if (r < 92)
                c = CMD_LOOKUP;
            else if (r < 95)
                c = CMD_CLEAR;
            else
                c = CMD_NOP;
            k = ($urandom_range(9) < 8) ? hot_keys[$urandom_range(23)] : rand_key();
            send_word(c, k, 1'($urandom_range(1)), rand_value());
        end

        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
